/* rtl/sha256_byte_stream_hasher_top_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the byte stream hasher checker
// ----------------------------------------------------------------------------
`ifndef SHA256_BYTE_STREAM_HASHER_TOP_ASSERT_SVH
`define SHA256_BYTE_STREAM_HASHER_TOP_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define SBSH_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define SBSH_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

/* rtl/sbsh_pkg.sv */
// ----------------------------------------------------------------------------
// sbsh_pkg
// Types, constants and round functions of the SHA-256 byte stream hasher.
// ----------------------------------------------------------------------------
package sbsh_pkg;

    typedef logic [31:0] t_word;

    localparam t_word K_ROUND [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam t_word H_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [7:0] PAD_MARK   = 8'h80;
    localparam logic [5:0] LEN_OFFSET = 6'd56;
    localparam logic [5:0] LAST_POS   = 6'd63;

    function automatic t_word rotr(input t_word x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic t_word big_s0(input t_word x);
        big_s0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic t_word big_s1(input t_word x);
        big_s1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic t_word small_s0(input t_word x);
        small_s0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic t_word small_s1(input t_word x);
        small_s1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

/* rtl/sha256_byte_stream_hasher_top.sv */
// ----------------------------------------------------------------------------
// sha256_byte_stream_hasher_top
// SHA-256 over a byte stream: buffer, pad, compress, emit eight digest words.
// ----------------------------------------------------------------------------
//  channel   dir  payload                                   handshake
//  s (in)    in   tdata=msg_byte, tuser=byte_present,       i_s_tvalid/o_s_tready
//                 tlast=end_message
//  m (out)   out  tdata=digest_word,word_index, tlast=last  o_m_tvalid/i_m_tready
//
//  Flow: a word with or without a byte is taken while idle; the word that
//  fills a 64-byte block starts 64 rounds of the shared round unit, then one
//  chaining add. End of message pads byte by byte up to the block end (one
//  or two blocks), compresses each padded block, then emits the eight digest
//  words, one per output handshake.
//  Reset: synchronous, active low; the chaining value returns to the initial
//  hash, counts clear. Input is not taken while a block or the digest is in
//  flight; a stalled digest word holds until taken.
// ----------------------------------------------------------------------------
module sha256_byte_stream_hasher_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] msg_byte
    input  logic        i_s_tuser,   // [0] byte_present
    input  logic        i_s_tlast,   // end_message
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,   // [31:0] digest_word, [34:32] word_index, zero fill
    output logic        o_m_tlast    // last_word
);
    import sbsh_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PAD  = 3'd1;
    localparam logic [2:0] S_COMP = 3'd2;
    localparam logic [2:0] S_ADD  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    localparam logic [1:0] AFT_IDLE = 2'd0;
    localparam logic [1:0] AFT_PAD  = 2'd1;
    localparam logic [1:0] AFT_OUT  = 2'd2;

    logic [2:0]   r_state, n_state;
    logic [1:0]   r_after, n_after;
    logic [5:0]   r_cnt, n_cnt;
    logic [63:0]  r_bits, n_bits;
    logic [5:0]   r_round, n_round;
    logic [2:0]   r_idx, n_idx;
    logic         r_mark, n_mark;
    logic         r_lenblk, n_lenblk;
    t_word        r_chain [8];
    t_word        n_chain [8];
    t_word        r_v [8];
    t_word        n_v [8];
    logic [511:0] r_blk, n_blk;   // block buffer, then rolling schedule (word 0 on top)

    logic         s_acc, m_acc;
    logic [7:0]   pad_byte;
    logic         cur_len;
    t_word        w0, w_new, t1, t2;

    assign s_acc = i_s_tvalid && o_s_tready;
    assign m_acc = o_m_tvalid && i_m_tready;

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = (r_state == S_OUT);
    assign o_m_tdata  = {5'd0, r_idx, r_chain[r_idx]};
    assign o_m_tlast  = (r_idx == 3'd7);

    // shared round unit and schedule expansion
    assign w0    = r_blk[511:480];
    assign w_new = small_s1(r_blk[63:32]) + r_blk[223:192] + small_s0(r_blk[479:448]) + w0;
    assign t1    = r_v[7] + big_s1(r_v[4]) + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
                 + K_ROUND[r_round] + w0;
    assign t2    = big_s0(r_v[0]) + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));

    // pad byte: mark, then zeros, length bytes in the last eight slots
    assign cur_len = r_mark ? (r_cnt < LEN_OFFSET) : r_lenblk;
    always_comb begin
        if (r_mark) begin
            pad_byte = PAD_MARK;
        end else if (r_lenblk && (r_cnt >= LEN_OFFSET)) begin
            pad_byte = r_bits[{3'd7 - r_cnt[2:0], 3'd0} +: 8];
        end else begin
            pad_byte = 8'd0;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_after  = r_after;
        n_cnt    = r_cnt;
        n_bits   = r_bits;
        n_round  = r_round;
        n_idx    = r_idx;
        n_mark   = r_mark;
        n_lenblk = r_lenblk;
        n_chain  = r_chain;
        n_v      = r_v;
        n_blk    = r_blk;
        unique case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    if (i_s_tlast) begin
                        n_mark = 1'b1;
                        n_state = S_PAD;
                    end
                    if (i_s_tuser) begin
                        n_blk  = {r_blk[503:0], i_s_tdata};
                        n_cnt  = r_cnt + 6'd1;
                        n_bits = r_bits + 64'd8;
                        if (r_cnt == LAST_POS) begin
                            // block full: compress, then pad or wait
                            n_after = i_s_tlast ? AFT_PAD : AFT_IDLE;
                            n_v     = r_chain;
                            n_round = 6'd0;
                            n_state = S_COMP;
                        end
                    end
                end
            end
            S_PAD: begin
                n_blk    = {r_blk[503:0], pad_byte};
                n_cnt    = r_cnt + 6'd1;
                n_mark   = 1'b0;
                n_lenblk = cur_len;
                if (r_cnt == LAST_POS) begin
                    n_after  = cur_len ? AFT_OUT : AFT_PAD;
                    n_lenblk = 1'b1;   // a following block carries the length
                    n_v      = r_chain;
                    n_round  = 6'd0;
                    n_state  = S_COMP;
                end
            end
            S_COMP: begin
                n_blk  = {r_blk[479:0], w_new};
                n_v[7] = r_v[6];
                n_v[6] = r_v[5];
                n_v[5] = r_v[4];
                n_v[4] = r_v[3] + t1;
                n_v[3] = r_v[2];
                n_v[2] = r_v[1];
                n_v[1] = r_v[0];
                n_v[0] = t1 + t2;
                n_round = r_round + 6'd1;
                if (r_round == LAST_POS) begin
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                for (int i = 0; i < 8; i++) begin
                    n_chain[i] = r_chain[i] + r_v[i];
                end
                n_idx = 3'd0;
                unique case (r_after)
                    AFT_PAD: n_state = S_PAD;
                    AFT_OUT: n_state = S_OUT;
                    default: n_state = S_IDLE;
                endcase
            end
            S_OUT: begin
                if (m_acc) begin
                    n_idx = r_idx + 3'd1;
                    if (r_idx == 3'd7) begin
                        // digest done: start a fresh message
                        n_chain  = H_INIT;
                        n_bits   = 64'd0;
                        n_cnt    = 6'd0;
                        n_lenblk = 1'b0;
                        n_state  = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_after  <= AFT_IDLE;
            r_cnt    <= 6'd0;
            r_bits   <= 64'd0;
            r_round  <= 6'd0;
            r_idx    <= 3'd0;
            r_mark   <= 1'b0;
            r_lenblk <= 1'b0;
            r_chain  <= H_INIT;
        end else begin
            r_state  <= n_state;
            r_after  <= n_after;
            r_cnt    <= n_cnt;
            r_bits   <= n_bits;
            r_round  <= n_round;
            r_idx    <= n_idx;
            r_mark   <= n_mark;
            r_lenblk <= n_lenblk;
            r_chain  <= n_chain;
        end
    end

    always_ff @(posedge i_clk) begin
        r_v   <= n_v;
        r_blk <= n_blk;
    end

endmodule

/* rtl/sbsh_checker.sv */
// ----------------------------------------------------------------------------
// sbsh_checker
// Port-level checks of the SHA-256 byte stream hasher.
// ----------------------------------------------------------------------------
`include "sha256_byte_stream_hasher_top_assert.svh"

module sbsh_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic [7:0]  i_s_tdata,
    input logic        i_s_tuser,
    input logic        i_s_tlast,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [39:0] o_m_tdata,
    input logic        o_m_tlast
);

    logic [2:0] m_idx;
    logic       m_acc;
    logic       m_stall;

    assign m_idx   = o_m_tdata[34:32];
    assign m_acc   = o_m_tvalid && i_m_tready;
    assign m_stall = o_m_tvalid && !i_m_tready;

    // hold a stalled digest word
    `SBSH_ASSERT(a_out_hold, m_stall |=> (o_m_tvalid && $stable(o_m_tdata)), "digest word changed")

    // last flag marks word seven
    `SBSH_ASSERT(a_last_idx, o_m_tvalid |-> (o_m_tlast == (m_idx == 3'd7)), "last flag off word seven")

    // no input taken while the digest is out
    `SBSH_ASSERT(a_excl, !(o_s_tready && o_m_tvalid), "input ready during digest output")

    // drop the output stream in the cycle after reset is sampled
    `SBSH_ASSERT_ALWAYS(a_rst_idle, !i_rst_n |=> !o_m_tvalid, "digest valid after reset")

    // advance word index by one after each word but the last
    `SBSH_ASSERT(a_idx_step, (m_acc && !o_m_tlast) |=> (o_m_tvalid && (m_idx == 3'($past(m_idx) + 3'd1))), "index skipped")

endmodule

bind sha256_byte_stream_hasher_top sbsh_checker u_sbsh_checker (.*);
